/* design/segment_to_segment_distance_defines.svh */
// Assertion macros shared by the segment distance design files.
`ifndef SEGMENT_TO_SEGMENT_DISTANCE_DEFINES_SVH
`define SEGMENT_TO_SEGMENT_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ssd_pkg.sv */
// Constants and types shared by the segment distance modules.
package ssd_pkg;

  // Coordinate and arithmetic widths.
  localparam int unsigned CoordBits = 32;
  localparam int unsigned NumCoords = 8;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned SumBits   = ProdBits + 1;
  localparam int unsigned HalfBits  = ProdBits / 2;
  localparam int unsigned NumBits   = 2 * ProdBits;
  localparam int unsigned QuotBits  = ProdBits;
  localparam int unsigned DistBits  = CoordBits + 1;
  localparam int unsigned RemBits   = DistBits + 2;

  // Port widths.
  localparam int unsigned InDataBits  = ((NumCoords * CoordBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((DistBits + 7) / 8) * 8;
  localparam int unsigned LenTolBits  = 16;
  localparam int unsigned AreaTolBits = 32;
  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 32;

  // Pipeline and queue sizes.
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned PtrBits     = $clog2(FifoDepth);
  localparam int unsigned FrontStages = 4;
  localparam int unsigned BackStages  = 3 + QuotBits + 2 + DistBits + 1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_LENGTH_TOL = 8'd0,
    REG_AREA_TOL   = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [LenTolBits-1:0]  len_tol;
    logic [AreaTolBits-1:0] area_tol;
  } ssd_cfg_t;

  // One point-to-segment candidate: squared length, or cross product over base.
  typedef struct packed {
    logic                perp;
    logic [ProdBits-1:0] mag;
    logic [ProdBits-1:0] den;
  } ssd_path_t;

  typedef struct packed {
    logic                  touch;
    ssd_path_t [3:0]       path;
  } ssd_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ssd_fifo_stat_t;

endpackage

/* design/segment_to_segment_distance.sv */
// Top level of the segment-to-segment minimum distance block.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata: a_start_x, a_start_y, a_end_x, a_end_y, b_start_x ...
//   m_axis    out        tdata: distance; tuser: touching
//   cfg       in         cfg_index_i selects length or area tolerance, cfg_data_i value
//
// One pair is taken per cycle when both sides flow. Each beat passes through the
// four-stage front, the 66-stage divider and the 33-stage square-root pipeline.
// Reset clears the valid bits and queue pointers and sets both tolerances to 1.
// A stalled output freezes the back end; the queue then fills and stops the front.
module segment_to_segment_distance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ssd_pkg::InDataBits-1:0]    s_axis_tdata,
  // Fields from bit 0 up: distance, then zero fill.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ssd_pkg::OutDataBits-1:0]   m_axis_tdata,
  // Fields from bit 0 up: touching.
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssd_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [ssd_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import ssd_pkg::*;

  ssd_cfg_t       cfg;
  logic [LenTolBits-1:0]  len_tol_q;
  logic [AreaTolBits-1:0] area_tol_q;
  logic           push, pop;
  ssd_job_t       job_in, job_out;
  ssd_fifo_stat_t fifo_stat;

  // Tolerance registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_tol_q  <= LenTolBits'(1);
      area_tol_q <= AreaTolBits'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LENGTH_TOL: len_tol_q  <= cfg_data_i[LenTolBits-1:0];
        REG_AREA_TOL:   area_tol_q <= cfg_data_i[AreaTolBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.len_tol  = len_tol_q;
  assign cfg.area_tol = area_tol_q;

  ssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .fifo_stat_i (fifo_stat),
    .pop_i       (pop),
    .push_o      (push),
    .job_o       (job_in)
  );

  ssd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (fifo_stat)
  );

  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fifo_stat_i (fifo_stat),
    .job_i       (job_out),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

/* design/ssd_front.sv */
// Front pipeline: takes coordinate beats, forms cross and dot products, classifies.
module ssd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssd_pkg::ssd_cfg_t            cfg_i,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [ssd_pkg::InDataBits-1:0] s_data_i,
  input  ssd_pkg::ssd_fifo_stat_t      fifo_stat_i,
  input  logic                         pop_i,
  output logic                         push_o,
  output ssd_pkg::ssd_job_t            job_o
);
  import ssd_pkg::*;

  localparam int unsigned BoxBits = CoordBits + 2;

  logic                        en;
  logic [FrontStages-1:0]      valid_q;
  logic signed [CoordBits-1:0] crd_q [NumCoords];
  logic signed [DiffBits-1:0]  dif_d [16];
  logic signed [DiffBits-1:0]  dif_q [16];
  logic [3:0]                  box_d, box2_q, box3_q, box4_q;
  logic signed [ProdBits-1:0]  prod_d [28];
  logic signed [ProdBits-1:0]  prod_q [28];
  logic signed [SumBits-1:0]   sum_d [14];
  logic signed [SumBits-1:0]   sum_q [14];
  logic [SumBits-1:0]          absd [4];
  logic [3:0]                  neg, zero, pos, near;
  logic                        cross_hit;

  function automatic logic signed [DiffBits-1:0] dsub(input logic signed [CoordBits-1:0] a,
                                                      input logic signed [CoordBits-1:0] b);
    return DiffBits'(a) - DiffBits'(b);
  endfunction

  function automatic logic signed [ProdBits-1:0] smul(input logic signed [DiffBits-1:0] a,
                                                      input logic signed [DiffBits-1:0] b);
    return a * b;
  endfunction

  // Point inside the box of two corners, widened by the length tolerance.
  function automatic logic in_box(input logic signed [CoordBits-1:0] px,
                                  input logic signed [CoordBits-1:0] py,
                                  input logic signed [CoordBits-1:0] ax,
                                  input logic signed [CoordBits-1:0] ay,
                                  input logic signed [CoordBits-1:0] bx,
                                  input logic signed [CoordBits-1:0] by,
                                  input logic [LenTolBits-1:0] tol);
    logic signed [BoxBits-1:0] t, xl, xh, yl, yh;
    logic                      outside;
    t  = $signed({{(BoxBits - LenTolBits){1'b0}}, tol});
    xl = BoxBits'(px) + t;
    xh = BoxBits'(px) - t;
    yl = BoxBits'(py) + t;
    yh = BoxBits'(py) - t;
    outside = (xl < BoxBits'(ax) && xl < BoxBits'(bx)) ||
              (xh > BoxBits'(ax) && xh > BoxBits'(bx)) ||
              (yl < BoxBits'(ay) && yl < BoxBits'(by)) ||
              (yh > BoxBits'(ay) && yh > BoxBits'(by));
    return !outside;
  endfunction

  // Nearest-point case for one endpoint against one segment.
  function automatic ssd_path_t make_path(input logic signed [SumBits-1:0] c1,
                                          input logic signed [SumBits-1:0] c2,
                                          input logic signed [SumBits-1:0] e_start,
                                          input logic signed [SumBits-1:0] e_end,
                                          input logic [SumBits-1:0] cr_abs);
    ssd_path_t r;
    r.den = c2[ProdBits-1:0];
    if (c1[SumBits-1] || c1 == '0) begin
      r.perp = 1'b0;
      r.mag  = e_start[ProdBits-1:0];
    end else if (c2 <= c1) begin
      r.perp = 1'b0;
      r.mag  = e_end[ProdBits-1:0];
    end else begin
      r.perp = 1'b1;
      r.mag  = cr_abs[ProdBits-1:0];
    end
    return r;
  endfunction

  // The whole front advances together while the queue has room or is being read.
  assign en        = !fifo_stat_i.full || pop_i;
  assign s_ready_o = en;
  assign push_o    = en && valid_q[FrontStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[FrontStages-2:0], s_valid_i};
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumCoords; i++) begin
        crd_q[i] <= s_data_i[i*CoordBits +: CoordBits];
      end
    end
  end

  // Edge vectors and tolerance boxes.
  always_comb begin
    dif_d[0]  = dsub(crd_q[2], crd_q[0]);  // A direction
    dif_d[1]  = dsub(crd_q[3], crd_q[1]);
    dif_d[2]  = dsub(crd_q[6], crd_q[4]);  // B direction
    dif_d[3]  = dsub(crd_q[7], crd_q[5]);
    dif_d[4]  = dsub(crd_q[4], crd_q[0]);  // B start minus A start
    dif_d[5]  = dsub(crd_q[5], crd_q[1]);
    dif_d[6]  = dsub(crd_q[6], crd_q[0]);  // B end minus A start
    dif_d[7]  = dsub(crd_q[7], crd_q[1]);
    dif_d[8]  = dsub(crd_q[4], crd_q[2]);  // B start minus A end
    dif_d[9]  = dsub(crd_q[5], crd_q[3]);
    dif_d[10] = dsub(crd_q[6], crd_q[2]);  // B end minus A end
    dif_d[11] = dsub(crd_q[7], crd_q[3]);
    dif_d[12] = dsub(crd_q[0], crd_q[4]);  // A start minus B start
    dif_d[13] = dsub(crd_q[1], crd_q[5]);
    dif_d[14] = dsub(crd_q[2], crd_q[4]);  // A end minus B start
    dif_d[15] = dsub(crd_q[3], crd_q[5]);
    box_d[0] = in_box(crd_q[0], crd_q[1], crd_q[4], crd_q[5], crd_q[6], crd_q[7],
                      cfg_i.len_tol);
    box_d[1] = in_box(crd_q[2], crd_q[3], crd_q[4], crd_q[5], crd_q[6], crd_q[7],
                      cfg_i.len_tol);
    box_d[2] = in_box(crd_q[4], crd_q[5], crd_q[0], crd_q[1], crd_q[2], crd_q[3],
                      cfg_i.len_tol);
    box_d[3] = in_box(crd_q[6], crd_q[7], crd_q[0], crd_q[1], crd_q[2], crd_q[3],
                      cfg_i.len_tol);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dif_q  <= dif_d;
      box2_q <= box_d;
    end
  end

  // Products, one multiplier each.
  always_comb begin
    prod_d[0]  = smul(dif_q[2],  dif_q[13]);
    prod_d[1]  = smul(dif_q[3],  dif_q[12]);
    prod_d[2]  = smul(dif_q[2],  dif_q[15]);
    prod_d[3]  = smul(dif_q[3],  dif_q[14]);
    prod_d[4]  = smul(dif_q[0],  dif_q[5]);
    prod_d[5]  = smul(dif_q[1],  dif_q[4]);
    prod_d[6]  = smul(dif_q[0],  dif_q[7]);
    prod_d[7]  = smul(dif_q[1],  dif_q[6]);
    prod_d[8]  = smul(dif_q[4],  dif_q[0]);
    prod_d[9]  = smul(dif_q[5],  dif_q[1]);
    prod_d[10] = smul(dif_q[6],  dif_q[0]);
    prod_d[11] = smul(dif_q[7],  dif_q[1]);
    prod_d[12] = smul(dif_q[12], dif_q[2]);
    prod_d[13] = smul(dif_q[13], dif_q[3]);
    prod_d[14] = smul(dif_q[14], dif_q[2]);
    prod_d[15] = smul(dif_q[15], dif_q[3]);
    prod_d[16] = smul(dif_q[0],  dif_q[0]);
    prod_d[17] = smul(dif_q[1],  dif_q[1]);
    prod_d[18] = smul(dif_q[2],  dif_q[2]);
    prod_d[19] = smul(dif_q[3],  dif_q[3]);
    prod_d[20] = smul(dif_q[4],  dif_q[4]);
    prod_d[21] = smul(dif_q[5],  dif_q[5]);
    prod_d[22] = smul(dif_q[6],  dif_q[6]);
    prod_d[23] = smul(dif_q[7],  dif_q[7]);
    prod_d[24] = smul(dif_q[8],  dif_q[8]);
    prod_d[25] = smul(dif_q[9],  dif_q[9]);
    prod_d[26] = smul(dif_q[10], dif_q[10]);
    prod_d[27] = smul(dif_q[11], dif_q[11]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      box3_q <= box2_q;
    end
  end

  // Cross products first, then dots, base lengths and endpoint distances.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_d[i] = SumBits'(prod_q[2*i]) - SumBits'(prod_q[2*i+1]);
    end
    for (int i = 4; i < 14; i++) begin
      sum_d[i] = SumBits'(prod_q[2*i]) + SumBits'(prod_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q  <= sum_d;
      box4_q <= box3_q;
    end
  end

  // Straddle and near-collinear tests, then the case of each candidate.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg[i]  = sum_q[i][SumBits-1];
      zero[i] = (sum_q[i] == '0);
      pos[i]  = !neg[i] && !zero[i];
      absd[i] = neg[i] ? SumBits'(-sum_q[i]) : SumBits'(sum_q[i]);
      near[i] = absd[i] < {{(SumBits - AreaTolBits){1'b0}}, cfg_i.area_tol};
    end
    cross_hit = ((neg[0] && pos[1]) || (pos[0] && neg[1])) &&
                ((neg[2] && pos[3]) || (pos[2] && neg[3]));
    job_o.touch   = cross_hit || |(near & box4_q);
    job_o.path[0] = make_path(sum_q[4], sum_q[8], sum_q[10], sum_q[12], absd[2]);
    job_o.path[1] = make_path(sum_q[5], sum_q[8], sum_q[11], sum_q[13], absd[3]);
    job_o.path[2] = make_path(sum_q[6], sum_q[9], sum_q[10], sum_q[11], absd[0]);
    job_o.path[3] = make_path(sum_q[7], sum_q[9], sum_q[12], sum_q[13], absd[1]);
  end

endmodule

/* design/ssd_fifo.sv */
// Short queue between the classifying front and the distance back end.
`include "segment_to_segment_distance_defines.svh"
module ssd_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ssd_pkg::ssd_job_t       job_i,
  input  logic                    pop_i,
  output ssd_pkg::ssd_job_t       job_o,
  output ssd_pkg::ssd_fifo_stat_t stat_o
);
  import ssd_pkg::*;

  ssd_job_t           mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q;

  assign stat_o.full  = (count_q == (PtrBits + 1)'(FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `SSD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= (PtrBits + 1)'(FifoDepth), "queue overfilled")
  `SSD_ASSERT_IMPL(a_push_full, push_i && stat_o.full, pop_i, "push into full queue")
  `SSD_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost")

endmodule

/* design/ssd_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module ssd_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ssd_pkg::NumBits-1:0]  num_i,
  input  logic [ssd_pkg::ProdBits-1:0] den_i,
  output logic [ssd_pkg::QuotBits-1:0] quo_o
);
  import ssd_pkg::*;

  logic [ProdBits-1:0] rem_q [QuotBits];
  logic [QuotBits-1:0] acc_q [QuotBits];
  logic [ProdBits-1:0] den_q [QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic [ProdBits-1:0] rem_in, den_in;
    logic [QuotBits-1:0] acc_in;
    logic [ProdBits:0]   trial, diff;
    logic                take;

    // The top half of the numerator is known to sit below the divisor.
    if (k == 0) begin : g_first
      assign rem_in = num_i[NumBits-1:QuotBits];
      assign acc_in = num_i[QuotBits-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, acc_in[QuotBits-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[ProdBits-1:0] : trial[ProdBits-1:0];
        acc_q[k] <= {acc_in[QuotBits-2:0], take};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = acc_q[QuotBits-1];

endmodule

/* design/ssd_back.sv */
// Back pipeline: squares, divides, takes the minimum and its integer root.
`include "segment_to_segment_distance_defines.svh"
module ssd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssd_pkg::ssd_cfg_t             cfg_i,
  input  ssd_pkg::ssd_fifo_stat_t       fifo_stat_i,
  input  ssd_pkg::ssd_job_t             job_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [ssd_pkg::OutDataBits-1:0] m_data_o,
  output logic                          m_user_o
);
  import ssd_pkg::*;

  logic                  en;
  logic [BackStages-1:0] valid_q;
  logic [BackStages-1:0] touch_q;
  ssd_job_t              job_q;
  logic                  perp1_q [4];
  logic [ProdBits-1:0]   mag1_q [4];
  logic [ProdBits-1:0]   den1_q [4];
  logic [ProdBits-1:0]   hh_q [4];
  logic [ProdBits-1:0]   hl_q [4];
  logic [ProdBits-1:0]   ll_q [4];
  logic [NumBits-1:0]    num2_q [4];
  logic [ProdBits-1:0]   den2_q [4];
  logic [QuotBits-1:0]   quo [4];
  logic [QuotBits-1:0]   min01_q, min23_q, qmin_q;
  logic [RemBits-1:0]    srem_q [DistBits];
  logic [DistBits-1:0]   sroot_q [DistBits];
  logic [QuotBits-1:0]   sacc_q [DistBits];
  logic [DistBits-1:0]   root;
  logic [DistBits-1:0]   dist_d, dist_q;

  // The back end moves as one while its output register can take a beat.
  assign en        = !valid_q[BackStages-1] || m_ready_i;
  assign pop_o     = en && !fifo_stat_i.empty;
  assign m_valid_o = valid_q[BackStages-1];
  assign m_user_o  = touch_q[BackStages-1];
  assign m_data_o  = OutDataBits'(dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[BackStages-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      touch_q <= {touch_q[BackStages-2:0], job_i.touch};
      job_q   <= job_i;
    end
  end

  // Partial products for the squared cross product.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        perp1_q[p] <= job_q.path[p].perp;
        mag1_q[p]  <= job_q.path[p].mag;
        den1_q[p]  <= job_q.path[p].den;
        hh_q[p]    <= ProdBits'(job_q.path[p].mag[ProdBits-1:HalfBits]) *
                      ProdBits'(job_q.path[p].mag[ProdBits-1:HalfBits]);
        hl_q[p]    <= ProdBits'(job_q.path[p].mag[ProdBits-1:HalfBits]) *
                      ProdBits'(job_q.path[p].mag[HalfBits-1:0]);
        ll_q[p]    <= ProdBits'(job_q.path[p].mag[HalfBits-1:0]) *
                      ProdBits'(job_q.path[p].mag[HalfBits-1:0]);
      end
    end
  end

  // Dividend and divisor; an endpoint distance divides by one.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        if (perp1_q[p]) begin
          num2_q[p] <= {hh_q[p], {ProdBits{1'b0}}} +
                       (NumBits'(hl_q[p]) << (HalfBits + 1)) + NumBits'(ll_q[p]);
          den2_q[p] <= den1_q[p];
        end else begin
          num2_q[p] <= NumBits'(mag1_q[p]);
          den2_q[p] <= ProdBits'(1);
        end
      end
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_div
    ssd_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num2_q[p]),
      .den_i (den2_q[p]),
      .quo_o (quo[p])
    );
  end

  // Two-level minimum of the squared candidate distances.
  always_ff @(posedge clk_i) begin
    if (en) begin
      min01_q <= (quo[0] < quo[1]) ? quo[0] : quo[1];
      min23_q <= (quo[2] < quo[3]) ? quo[2] : quo[3];
      qmin_q  <= (min01_q < min23_q) ? min01_q : min23_q;
    end
  end

  // Digit-by-digit integer square root, one root bit per stage.
  for (genvar k = 0; k < DistBits; k++) begin : g_sqrt
    logic [RemBits-1:0]  rem_in;
    logic [DistBits-1:0] root_in;
    logic [QuotBits-1:0] acc_in;
    logic [RemBits+1:0]  trial, tst, diff;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign acc_in  = qmin_q;
    end else begin : g_next
      assign rem_in  = srem_q[k-1];
      assign root_in = sroot_q[k-1];
      assign acc_in  = sacc_q[k-1];
    end

    assign trial = {rem_in, acc_in[QuotBits-1 -: 2]};
    assign tst   = (RemBits + 2)'({root_in, 2'b01});
    assign diff  = trial - tst;
    assign take  = (trial >= tst);

    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[k]  <= take ? diff[RemBits-1:0] : trial[RemBits-1:0];
        sroot_q[k] <= {root_in[DistBits-2:0], take};
        sacc_q[k]  <= {acc_in[QuotBits-3:0], 2'b00};
      end
    end
  end

  assign root = sroot_q[DistBits-1];

  // Touching pairs and distances under the length tolerance read as zero.
  always_comb begin
    if (touch_q[BackStages-2] || root < DistBits'(cfg_i.len_tol)) begin
      dist_d = '0;
    end else begin
      dist_d = root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
    end
  end

  `SSD_ASSERT_IMPL(a_touch_zero, m_valid_o && m_user_o, dist_q == '0, "touching pair not zero")
  `SSD_ASSERT_IMPL(a_dist_tol, m_valid_o && dist_q != '0,
                   dist_q >= DistBits'(cfg_i.len_tol), "distance below tolerance")

endmodule
